// ===== sv/skbp_pkg.sv =====
package skbp_pkg;

	localparam int ACC_W = 56;
	localparam int MA_W = 24;
	localparam int MB_W = 34;
	localparam int SCR_W = 20;
	localparam int LEN_W = 44;
	localparam int T_W = 17;
	localparam int DIV_STEPS = 16;

	localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
	localparam logic signed [ACC_W-1:0] BEST_INIT = ACC_W'(36864);
	localparam logic signed [ACC_W-1:0] CLAMP_LIM = ACC_W'(262144);
	localparam logic [T_W-1:0] T_ONE = T_W'(65536);
	localparam logic signed [20:0] NDC_ONE = 21'sd65536;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_PICK = 1'b1;

	localparam logic [2:0] REG_SHOW = 3'd0;
	localparam logic [2:0] REG_YAW = 3'd1;
	localparam logic [2:0] REG_PITCH = 3'd2;
	localparam logic [2:0] REG_CENTER = 3'd3;
	localparam logic [2:0] REG_INV_W = 3'd4;
	localparam logic [2:0] REG_INV_H = 3'd5;
	localparam logic [2:0] REG_CANVAS_W = 3'd6;
	localparam logic [2:0] REG_CANVAS_H = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_J, ST_LD_J, ST_RD_P, ST_LD_P,
		ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
		ST_D0, ST_D1, ST_D2,
		ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_G6, ST_G7,
		ST_DIV, ST_FIN
	} skbp_state_t;

	typedef enum logic [1:0] {
		ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
	} skbp_acc_op_t;

	function automatic logic signed [ACC_W-1:0] rnd_shr(input logic signed [ACC_W-1:0] v,
			input int unsigned n);
		logic signed [ACC_W-1:0] h;
		h = ACC_W'(1) <<< (n - 1);
		return (v + h) >>> n;
	endfunction

	function automatic logic signed [ACC_W-1:0] clamp4(input logic signed [ACC_W-1:0] v);
		if (v > CLAMP_LIM) begin
			return CLAMP_LIM;
		end
		if (v < -CLAMP_LIM) begin
			return -CLAMP_LIM;
		end
		return v;
	endfunction

endpackage

// ===== sv/skbp_ram.sv =====
module skbp_ram import skbp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/skeleton_bone_pick_core.sv =====
// skeleton bone picker
// load words (func = 0) write one bone slot: position, parent slot and id.
// a load gives no result; slots at or above MAX_BONES are dropped.
// pick words (func = 1) carry the mouse point and the bone count and give
// exactly one result word: picked_valid and picked_bone.
// in_valid/in_stall and out_valid/out_stall carry the words; cfg_valid/cfg_ready
// writes the view registers and is always ready; write them only while idle.
// a pick runs on one shared multiplier plus a 16-step divider under a small
// sequencer: it projects each bone's joint and measures its distance to the
// mouse, and also the distance to the segment up to a valid parent joint.
// a hidden skeleton or a count of zero answers without walking the bones.
// in_stall is high while a pick runs.
// the result sits in an output register; a new word is taken while it waits,
// and a later pick holds at its end until the register is free.
// reset puts the view registers to their defaults and clears the handshakes; bone
// slots are undefined until loaded.
module skeleton_bone_pick_core import skbp_pkg::*; #(
	parameter int MAX_BONES = 64,
	parameter int COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [5:0]         bone_slot,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic signed [6:0]  parent_slot,
	input  logic [15:0]        bone_id,
	input  logic signed [15:0] mouse_x,
	input  logic signed [15:0] mouse_y,
	input  logic [6:0]         bone_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               picked_valid,
	output logic [15:0]        picked_bone,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int CNT_W = $clog2(MAX_BONES + 1);
	localparam int PC_W = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int POS_W = 3 * PC_W;
	localparam int LINK_W = 23;

	skbp_state_t state_q, state_d;
	skbp_acc_op_t acc_op;

	logic        show_q;
	logic [31:0] yaw_q, pitch_q, inv_w_q, inv_h_q;
	logic [47:0] center_q;
	logic [10:0] cw_q, ch_q;

	logic               out_valid_q;
	logic               res_valid_q;
	logic [15:0]        res_bone_q;

	logic                    in_acc, load_we;
	logic [AW-1:0]           raddr;
	logic [POS_W-1:0]        pos_rd;
	logic [LINK_W-1:0]       link_rd;
	logic [CNT_W-1:0]        count_in;

	logic signed [15:0]      mx_q, my_q;
	logic [CNT_W-1:0]        count_q, i_q;
	logic signed [6:0]       parent_q;
	logic [15:0]             id_q, best_id_q;
	logic                    par_q, found_q;
	logic signed [ACC_W-1:0] acc_q, best_q;
	logic signed [16:0]      dx_q, dy_q, dz_q;
	logic signed [21:0]      x1_q, z1_q, y2_q;
	logic signed [SCR_W-1:0] nx_q, ny_q, sx_q, jx_q, jy_q, qx_q, qy_q, tx_q, ty_q;
	logic [LEN_W-1:0]        len2_q;
	logic [LEN_W:0]          rem_q;
	logic [T_W-1:0]          t_q;
	logic [4:0]              div_cnt_q;

	logic signed [MA_W-1:0]       mul_a;
	logic signed [MB_W-1:0]       mul_b;
	logic signed [MA_W+MB_W-1:0]  prod;
	logic signed [ACC_W-1:0]      prod_t, rnd_v;
	logic signed [16:0]           ex, ey, ez;
	logic signed [20:0]           dmx_t, dmy_t, dmx_q0, dmy_q0, gx, gy;
	logic signed [15:0]           cy_s, sy_s, cp_s, sp_s;
	logic                         parent_ok, last_bone;
	logic [LEN_W:0]               r2;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign load_we = in_acc && (func == FUNC_LOAD) && (32'(bone_slot) < 32'(MAX_BONES));
	assign out_valid = out_valid_q;
	assign picked_valid = res_valid_q;
	assign picked_bone = res_bone_q;

	assign count_in = (32'(bone_count) > 32'(MAX_BONES)) ? CNT_W'(MAX_BONES)
		: CNT_W'(bone_count);

	skbp_ram #(.WIDTH(POS_W), .DEPTH(MAX_BONES)) u_pos_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(bone_slot)),
		.wdata ({pos_x[PC_W-1:0], pos_y[PC_W-1:0], pos_z[PC_W-1:0]}),
		.raddr (raddr),
		.rdata (pos_rd)
	);

	skbp_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BONES)) u_link_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(bone_slot)),
		.wdata ({parent_slot, bone_id}),
		.raddr (raddr),
		.rdata (link_rd)
	);

	assign cy_s = signed'(yaw_q[31:16]);
	assign sy_s = signed'(yaw_q[15:0]);
	assign cp_s = signed'(pitch_q[31:16]);
	assign sp_s = signed'(pitch_q[15:0]);

	assign ex = 17'(signed'(pos_rd[3*PC_W-1:2*PC_W])) - 17'(signed'(center_q[47:32]));
	assign ey = 17'(signed'(pos_rd[2*PC_W-1:PC_W])) - 17'(signed'(center_q[31:16]));
	assign ez = 17'(signed'(pos_rd[PC_W-1:0])) - 17'(signed'(center_q[15:0]));

	assign dmx_t = 21'(mx_q) - 21'(tx_q);
	assign dmy_t = 21'(my_q) - 21'(ty_q);
	assign dmx_q0 = 21'(mx_q) - 21'(qx_q);
	assign dmy_q0 = 21'(my_q) - 21'(qy_q);
	assign gx = 21'(jx_q) - 21'(qx_q);
	assign gy = 21'(jy_q) - 21'(qy_q);

	assign parent_ok = !parent_q[6] && (32'(parent_q[5:0]) < 32'(count_q));
	assign last_bone = (32'(i_q) + 32'd1 == 32'(count_q));
	assign r2 = {rem_q[LEN_W-1:0], 1'b0};

	assign prod = mul_a * mul_b;
	assign prod_t = prod[ACC_W-1:0];

	always_comb begin
		state_d = state_q;
		acc_op = ACC_HOLD;
		mul_a = '0;
		mul_b = '0;
		raddr = i_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_acc && func == FUNC_PICK) begin
					state_d = (show_q && count_in != '0) ? ST_RD_J : ST_FIN;
				end
			end
			ST_RD_J: state_d = ST_LD_J;
			ST_LD_J: state_d = ST_M0;
			ST_RD_P: begin
				raddr = AW'(unsigned'(parent_q));
				state_d = ST_LD_P;
			end
			ST_LD_P: state_d = ST_M0;
			ST_M0: begin
				mul_a = MA_W'(dx_q); mul_b = MB_W'(cy_s); acc_op = ACC_LOAD;
				state_d = ST_M1;
			end
			ST_M1: begin
				mul_a = MA_W'(dz_q); mul_b = MB_W'(sy_s); acc_op = ACC_ADD;
				state_d = ST_M2;
			end
			ST_M2: begin
				mul_a = MA_W'(dz_q); mul_b = MB_W'(cy_s); acc_op = ACC_LOAD;
				state_d = ST_M3;
			end
			ST_M3: begin
				mul_a = MA_W'(dx_q); mul_b = MB_W'(sy_s); acc_op = ACC_SUB;
				state_d = ST_M4;
			end
			ST_M4: begin
				mul_a = MA_W'(dy_q); mul_b = MB_W'(cp_s); acc_op = ACC_LOAD;
				state_d = ST_M5;
			end
			ST_M5: begin
				mul_a = MA_W'(z1_q); mul_b = MB_W'(sp_s); acc_op = ACC_SUB;
				state_d = ST_M6;
			end
			ST_M6: begin
				mul_a = MA_W'(x1_q); mul_b = MB_W'({1'b0, inv_w_q}); acc_op = ACC_LOAD;
				state_d = ST_M7;
			end
			ST_M7: begin
				mul_a = MA_W'(y2_q); mul_b = MB_W'({1'b0, inv_h_q}); acc_op = ACC_LOAD;
				state_d = ST_M8;
			end
			ST_M8: begin
				mul_a = MA_W'(21'(nx_q) + NDC_ONE); mul_b = MB_W'({1'b0, cw_q});
				acc_op = ACC_LOAD;
				state_d = ST_M9;
			end
			ST_M9: begin
				mul_a = MA_W'(NDC_ONE - 21'(ny_q)); mul_b = MB_W'({1'b0, ch_q});
				acc_op = ACC_LOAD;
				state_d = ST_M10;
			end
			ST_M10: state_d = par_q ? ST_G0 : ST_D0;
			ST_D0: begin
				mul_a = MA_W'(dmx_t); mul_b = MB_W'(dmx_t); acc_op = ACC_LOAD;
				state_d = ST_D1;
			end
			ST_D1: begin
				mul_a = MA_W'(dmy_t); mul_b = MB_W'(dmy_t); acc_op = ACC_ADD;
				state_d = ST_D2;
			end
			ST_D2: begin
				if (!par_q && parent_ok) begin
					state_d = ST_RD_P;
				end else begin
					state_d = last_bone ? ST_FIN : ST_RD_J;
				end
			end
			ST_G0: begin
				mul_a = MA_W'(gx); mul_b = MB_W'(gx); acc_op = ACC_LOAD;
				state_d = ST_G1;
			end
			ST_G1: begin
				mul_a = MA_W'(gy); mul_b = MB_W'(gy); acc_op = ACC_ADD;
				state_d = ST_G2;
			end
			ST_G2: begin
				mul_a = MA_W'(dmx_q0); mul_b = MB_W'(gx); acc_op = ACC_LOAD;
				state_d = (acc_q == ACC_ZERO) ? ST_D0 : ST_G3;
			end
			ST_G3: begin
				mul_a = MA_W'(dmy_q0); mul_b = MB_W'(gy); acc_op = ACC_ADD;
				state_d = ST_G4;
			end
			ST_G4: begin
				if (acc_q <= ACC_ZERO || acc_q >= signed'({1'b0, len2_q})) begin
					state_d = ST_G5;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = ST_G5;
				end
			end
			ST_G5: begin
				mul_a = MA_W'({1'b0, t_q}); mul_b = MB_W'(gx); acc_op = ACC_LOAD;
				state_d = ST_G6;
			end
			ST_G6: begin
				mul_a = MA_W'({1'b0, t_q}); mul_b = MB_W'(gy); acc_op = ACC_LOAD;
				state_d = ST_G7;
			end
			ST_G7: state_d = ST_D0;
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_q <= 1'b0;
			yaw_q <= 32'd16384;
			pitch_q <= 32'd16384;
			center_q <= '0;
			inv_w_q <= 32'd65536;
			inv_h_q <= 32'd65536;
			cw_q <= 11'd512;
			ch_q <= 11'd512;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHOW: show_q <= cfg_data[0];
				REG_YAW: yaw_q <= cfg_data[31:0];
				REG_PITCH: pitch_q <= cfg_data[31:0];
				REG_CENTER: center_q <= cfg_data;
				REG_INV_W: inv_w_q <= cfg_data[31:0];
				REG_INV_H: inv_h_q <= cfg_data[31:0];
				REG_CANVAS_W: cw_q <= cfg_data[10:0];
				REG_CANVAS_H: ch_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_bone_q <= '0;
		end else begin
			if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				res_valid_q <= found_q;
				res_bone_q <= found_q ? best_id_q : 16'd0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			par_q <= 1'b0;
			i_q <= '0;
			count_q <= '0;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && func == FUNC_PICK) begin
						found_q <= 1'b0;
						par_q <= 1'b0;
						i_q <= '0;
						count_q <= count_in;
					end
				end
				ST_RD_P: par_q <= 1'b1;
				ST_D2: begin
					if (acc_q < best_q) begin
						found_q <= 1'b1;
					end
					if (par_q || !parent_ok) begin
						par_q <= 1'b0;
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_G4: div_cnt_q <= '0;
				ST_DIV: div_cnt_q <= div_cnt_q + 5'd1;
				default: ;
			endcase
		end
	end

	assign rnd_v = (state_q == ST_M2 || state_q == ST_M4 || state_q == ST_M6)
		? rnd_shr(acc_q, 14)
		: (state_q == ST_M7 || state_q == ST_M8) ? clamp4(rnd_shr(acc_q, 8))
		: (state_q == ST_M9 || state_q == ST_M10) ? rnd_shr(acc_q, 13)
		: rnd_shr(acc_q, 16);

	// datapath
	always_ff @(posedge clk) begin
		case (acc_op)
			ACC_LOAD: acc_q <= prod_t;
			ACC_ADD: acc_q <= acc_q + prod_t;
			ACC_SUB: acc_q <= acc_q - prod_t;
			default: ;
		endcase
		case (state_q)
			ST_IDLE: begin
				mx_q <= mouse_x;
				my_q <= mouse_y;
				best_q <= BEST_INIT;
				best_id_q <= '0;
			end
			ST_LD_J: begin
				dx_q <= ex; dy_q <= ey; dz_q <= ez;
				parent_q <= signed'(link_rd[22:16]);
				id_q <= link_rd[15:0];
			end
			ST_LD_P: begin
				dx_q <= ex; dy_q <= ey; dz_q <= ez;
			end
			ST_M2: x1_q <= 22'(rnd_v);
			ST_M4: z1_q <= 22'(rnd_v);
			ST_M6: y2_q <= 22'(rnd_v);
			ST_M7: nx_q <= SCR_W'(rnd_v);
			ST_M8: ny_q <= SCR_W'(rnd_v);
			ST_M9: sx_q <= SCR_W'(rnd_v);
			ST_M10: begin
				if (par_q) begin
					qx_q <= sx_q;
					qy_q <= SCR_W'(rnd_v);
				end else begin
					jx_q <= sx_q;
					jy_q <= SCR_W'(rnd_v);
					tx_q <= sx_q;
					ty_q <= SCR_W'(rnd_v);
				end
			end
			ST_D2: begin
				if (acc_q < best_q) begin
					best_q <= acc_q;
					best_id_q <= id_q;
				end
			end
			ST_G2: begin
				len2_q <= acc_q[LEN_W-1:0];
				tx_q <= qx_q;
				ty_q <= qy_q;
			end
			ST_G4: begin
				rem_q <= {1'b0, acc_q[LEN_W-1:0]};
				t_q <= (acc_q >= signed'({1'b0, len2_q})) ? T_ONE : '0;
			end
			ST_DIV: begin
				if (r2 >= {1'b0, len2_q}) begin
					rem_q <= r2 - {1'b0, len2_q};
					t_q <= {t_q[T_W-2:0], 1'b1};
				end else begin
					rem_q <= r2;
					t_q <= {t_q[T_W-2:0], 1'b0};
				end
			end
			ST_G6: tx_q <= qx_q + SCR_W'(rnd_v);
			ST_G7: ty_q <= qy_q + SCR_W'(rnd_v);
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> len2_q != '0)
		else $error("divider running on a zero segment length");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_valid_q |-> res_bone_q == 16'd0)
		else $error("bone id reported with no pick");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD_J |-> i_q < count_q)
		else $error("bone walk past the count");

endmodule
